/* rtl/wav_riff_stream_parser_assert.svh */
// Assertion macros for the WAV stream parser (clock clk, reset rst_n).
`ifndef WAV_RIFF_STREAM_PARSER_ASSERT_SVH
`define WAV_RIFF_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication.
`define WRSP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WRSP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wrsp_pkg.sv */
// Shared types and constants of the WAV stream parser.
`default_nettype none

package wrsp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_BODY_MIN = 32'd16;
    localparam logic [15:0] PCM_TAG      = 16'd1;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam int unsigned NUM_RATES = 9;
    localparam logic [31:0] RATE_LIST [NUM_RATES] = '{
        32'd48000, 32'd44100, 32'd32000, 32'd24000, 32'd22050,
        32'd16000, 32'd12000, 32'd11025, 32'd8000
    };

    typedef struct packed {
        logic [15:0] fmt_tag;
        logic [15:0] chan;
        logic [31:0] rate;
        logic [15:0] bits;
    } fmt_fields_t;

endpackage

`default_nettype wire

/* rtl/wrsp_in_if.sv */
// Input channel: one file byte per word.
`default_nettype none

interface wrsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_final;

    modport source (output valid, output in_byte, output is_final, input ready);
    modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

`default_nettype wire

/* rtl/wrsp_out_if.sv */
// Result channel: one parser event per word.
`default_nettype none

interface wrsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  num_chan;
    logic [4:0]  sample_bits;
    logic [15:0] rate_hz;
    logic [1:0]  frame_pos;
    logic        frame_done;
    logic        stream_done;

    modport source (
        output valid, output kind, output out_byte, output num_chan,
        output sample_bits, output rate_hz, output frame_pos,
        output frame_done, output stream_done, input ready
    );
    modport sink (
        input valid, input kind, input out_byte, input num_chan,
        input sample_bits, input rate_hz, input frame_pos,
        input frame_done, input stream_done, output ready
    );
endinterface

`default_nettype wire

/* rtl/wrsp_fmt_check.sv */
// PCM fmt chunk field validation.
`default_nettype none

module wrsp_fmt_check (
    input  wrsp_pkg::fmt_fields_t fields,
    output logic                  fmt_ok
);

    logic rate_ok;

    always_comb
    begin
        rate_ok = 1'b0;
        for (int i = 0; i < wrsp_pkg::NUM_RATES; i++)
        begin
            if (fields.rate == wrsp_pkg::RATE_LIST[i])
            begin
                rate_ok = 1'b1;
            end
        end
    end

    assign fmt_ok = (fields.fmt_tag == wrsp_pkg::PCM_TAG)
                 && (fields.chan == 16'd1 || fields.chan == 16'd2)
                 && rate_ok
                 && (fields.bits == 16'd8 || fields.bits == 16'd16);

endmodule

`default_nettype wire

/* rtl/wav_riff_stream_parser.sv */
// WAV (RIFF/WAVE PCM) byte stream parser, top level.
// Takes one file byte per word and emits at most one event per byte: a sample
// byte with its frame position, format accepted, stream rejected, or end of
// stream on the byte marked final. A byte is taken in every cycle in which
// the result register is empty or its word is being taken, so the sustained
// rate is one byte per cycle and the event for a byte appears on the result
// channel in the following cycle. The parser returns to its reset state
// after the final byte.
`default_nettype none

`include "wav_riff_stream_parser_assert.svh"

module wav_riff_stream_parser (
    input  logic              clk,
    input  logic              rst_n,
    wrsp_in_if.sink           stream,
    wrsp_out_if.source        result
);

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_HDR  = 3'd1,
        PH_FMT  = 3'd2,
        PH_SKIP = 3'd3,
        PH_TAIL = 3'd4,
        PH_DATA = 3'd5,
        PH_REJ  = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  byte_count_reg, byte_count_next;
    logic [31:0] tag_shift_reg, tag_shift_next;
    logic [31:0] chunk_left_reg, chunk_left_next;
    logic        riff_nz_reg, riff_nz_next;
    logic [15:0] fmt_tag_reg, fmt_tag_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        format_found_reg, format_found_next;
    logic [1:0]  frame_index_reg, frame_index_next;

    logic        res_valid_reg, res_valid_next;
    logic [1:0]  res_kind_reg, res_kind_next;
    logic [7:0]  res_byte_reg, res_byte_next;
    logic [1:0]  res_chan_reg, res_chan_next;
    logic [4:0]  res_bits_reg, res_bits_next;
    logic [15:0] res_rate_reg, res_rate_next;
    logic [1:0]  res_fpos_reg, res_fpos_next;
    logic        res_fdone_reg, res_fdone_next;
    logic        res_sdone_reg, res_sdone_next;

    logic        accept;
    logic        has_result;
    logic [7:0]  b;
    logic        fin;

    wrsp_pkg::fmt_fields_t fmt_cand;
    logic                  fmt_ok;
    logic [28:0]           frame_bytes;
    logic [31:0]           last_idx;

    assign b      = stream.in_byte;
    assign fin    = stream.is_final;
    assign accept = stream.valid && stream.ready;
    assign stream.ready = !res_valid_reg || result.ready;

    // fmt body fields after this byte, little endian
    always_comb
    begin
        fmt_cand.fmt_tag = fmt_tag_reg;
        fmt_cand.chan    = chan_reg;
        fmt_cand.rate    = rate_reg;
        fmt_cand.bits    = bits_reg;
        if (byte_count_reg < 4'd2)
        begin
            fmt_cand.fmt_tag = {b, fmt_tag_reg[15:8]};
        end
        else if (byte_count_reg < 4'd4)
        begin
            fmt_cand.chan = {b, chan_reg[15:8]};
        end
        else if (byte_count_reg < 4'd8)
        begin
            fmt_cand.rate = {b, rate_reg[31:8]};
        end
        else if (byte_count_reg >= 4'd14)
        begin
            fmt_cand.bits = {b, bits_reg[15:8]};
        end
    end

    wrsp_fmt_check u_fmt_check (
        .fields (fmt_cand),
        .fmt_ok (fmt_ok)
    );

    assign frame_bytes = 29'(chan_reg) * 29'(bits_reg[15:3]);
    assign last_idx    = {3'b000, frame_bytes} - 32'd1;

    always_comb
    begin
        logic ev_sample;
        logic ev_accept;
        logic ev_reject;
        logic rejected_before;

        ev_sample = 1'b0;
        ev_accept = 1'b0;
        ev_reject = 1'b0;
        rejected_before = (phase_reg != PH_RIFF) && (phase_reg != PH_HDR)
                       && (phase_reg != PH_FMT) && (phase_reg != PH_SKIP)
                       && (phase_reg != PH_TAIL) && (phase_reg != PH_DATA);

        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        tag_shift_next    = tag_shift_reg;
        chunk_left_next   = chunk_left_reg;
        riff_nz_next      = riff_nz_reg;
        fmt_tag_next      = fmt_tag_reg;
        chan_next         = chan_reg;
        rate_next         = rate_reg;
        bits_next         = bits_reg;
        format_found_next = format_found_reg;
        frame_index_next  = frame_index_reg;

        res_byte_next  = 8'd0;
        res_fpos_next  = 2'd0;
        res_fdone_next = 1'b0;
        res_kind_next  = wrsp_pkg::KIND_SAMPLE;

        case (phase_reg)
            PH_RIFF:
            begin
                if (byte_count_reg < 4'd4 || byte_count_reg >= 4'd8)
                begin
                    tag_shift_next = {tag_shift_reg[23:0], b};
                end
                else if (b != 8'd0)
                begin
                    riff_nz_next = 1'b1;
                end
                if (byte_count_reg == 4'd3 && tag_shift_next != wrsp_pkg::TAG_RIFF)
                begin
                    phase_next = PH_REJ;
                    ev_reject  = 1'b1;
                end
                else if (byte_count_reg >= 4'd11)
                begin
                    byte_count_next = 4'd0;
                    if (!riff_nz_next || tag_shift_next != wrsp_pkg::TAG_WAVE)
                    begin
                        phase_next = PH_REJ;
                        ev_reject  = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_HDR;
                    end
                end
                else
                begin
                    byte_count_next = byte_count_reg + 4'd1;
                end
            end
            PH_HDR:
            begin
                if (byte_count_reg < 4'd4)
                begin
                    tag_shift_next = {tag_shift_reg[23:0], b};
                end
                else
                begin
                    chunk_left_next = {b, chunk_left_reg[31:8]};
                end
                if (byte_count_reg >= 4'd7)
                begin
                    byte_count_next = 4'd0;
                    if (!format_found_reg && tag_shift_next == wrsp_pkg::TAG_FMT
                        && chunk_left_next >= wrsp_pkg::FMT_BODY_MIN)
                    begin
                        chunk_left_next = chunk_left_next - wrsp_pkg::FMT_BODY_MIN;
                        phase_next      = PH_FMT;
                    end
                    else if (format_found_reg && tag_shift_next == wrsp_pkg::TAG_DATA)
                    begin
                        phase_next = (chunk_left_next == 32'd0) ? PH_HDR : PH_DATA;
                    end
                    else
                    begin
                        phase_next = (chunk_left_next == 32'd0) ? PH_HDR : PH_SKIP;
                    end
                end
                else
                begin
                    byte_count_next = byte_count_reg + 4'd1;
                end
            end
            PH_FMT:
            begin
                fmt_tag_next = fmt_cand.fmt_tag;
                chan_next    = fmt_cand.chan;
                rate_next    = fmt_cand.rate;
                bits_next    = fmt_cand.bits;
                if (byte_count_reg >= 4'd15)
                begin
                    byte_count_next = 4'd0;
                    if (!fmt_ok)
                    begin
                        phase_next = PH_REJ;
                        ev_reject  = 1'b1;
                    end
                    else if (chunk_left_reg == 32'd0)
                    begin
                        format_found_next = 1'b1;
                        phase_next        = PH_HDR;
                        ev_accept         = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TAIL;
                    end
                end
                else
                begin
                    byte_count_next = byte_count_reg + 4'd1;
                end
            end
            PH_SKIP:
            begin
                chunk_left_next = chunk_left_reg - 32'd1;
                if (chunk_left_next == 32'd0)
                begin
                    phase_next = PH_HDR;
                end
            end
            PH_TAIL:
            begin
                chunk_left_next = chunk_left_reg - 32'd1;
                if (chunk_left_next == 32'd0)
                begin
                    format_found_next = 1'b1;
                    phase_next        = PH_HDR;
                    ev_accept         = 1'b1;
                end
            end
            PH_DATA:
            begin
                ev_sample     = 1'b1;
                res_byte_next = b;
                res_fpos_next = frame_index_reg;
                if ({30'd0, frame_index_reg} >= last_idx)
                begin
                    res_fdone_next   = 1'b1;
                    frame_index_next = 2'd0;
                end
                else
                begin
                    frame_index_next = frame_index_reg + 2'd1;
                end
                chunk_left_next = chunk_left_reg - 32'd1;
                if (chunk_left_next == 32'd0)
                begin
                    phase_next = PH_HDR;
                end
            end
            default:
            begin
            end
        endcase

        has_result = ev_sample || ev_accept || ev_reject || fin;

        if (ev_sample)
        begin
            res_kind_next = wrsp_pkg::KIND_SAMPLE;
        end
        else if (ev_accept)
        begin
            res_kind_next = wrsp_pkg::KIND_FORMAT;
        end
        else if (ev_reject)
        begin
            res_kind_next = wrsp_pkg::KIND_REJECT;
        end
        else if (!format_found_next && !rejected_before)
        begin
            res_kind_next = wrsp_pkg::KIND_REJECT;
        end
        else
        begin
            res_kind_next = wrsp_pkg::KIND_END;
            res_fpos_next = frame_index_next;
        end

        res_chan_next  = format_found_next ? chan_next[1:0] : 2'd0;
        res_bits_next  = format_found_next ? bits_next[4:0] : 5'd0;
        res_rate_next  = format_found_next ? rate_next[15:0] : 16'd0;
        res_sdone_next = fin;

        if (fin)
        begin
            phase_next        = PH_RIFF;
            byte_count_next   = 4'd0;
            tag_shift_next    = 32'd0;
            chunk_left_next   = 32'd0;
            riff_nz_next      = 1'b0;
            fmt_tag_next      = 16'd0;
            chan_next         = 16'd0;
            rate_next         = 32'd0;
            bits_next         = 16'd0;
            format_found_next = 1'b0;
            frame_index_next  = 2'd0;
        end

        if (accept)
        begin
            res_valid_next = has_result;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_RIFF;
            byte_count_reg   <= 4'd0;
            tag_shift_reg    <= 32'd0;
            chunk_left_reg   <= 32'd0;
            riff_nz_reg      <= 1'b0;
            fmt_tag_reg      <= 16'd0;
            chan_reg         <= 16'd0;
            rate_reg         <= 32'd0;
            bits_reg         <= 16'd0;
            format_found_reg <= 1'b0;
            frame_index_reg  <= 2'd0;
            res_valid_reg    <= 1'b0;
            res_kind_reg     <= wrsp_pkg::KIND_SAMPLE;
            res_byte_reg     <= 8'd0;
            res_chan_reg     <= 2'd0;
            res_bits_reg     <= 5'd0;
            res_rate_reg     <= 16'd0;
            res_fpos_reg     <= 2'd0;
            res_fdone_reg    <= 1'b0;
            res_sdone_reg    <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                phase_reg        <= phase_next;
                byte_count_reg   <= byte_count_next;
                tag_shift_reg    <= tag_shift_next;
                chunk_left_reg   <= chunk_left_next;
                riff_nz_reg      <= riff_nz_next;
                fmt_tag_reg      <= fmt_tag_next;
                chan_reg         <= chan_next;
                rate_reg         <= rate_next;
                bits_reg         <= bits_next;
                format_found_reg <= format_found_next;
                frame_index_reg  <= frame_index_next;
                if (has_result)
                begin
                    res_kind_reg  <= res_kind_next;
                    res_byte_reg  <= res_byte_next;
                    res_chan_reg  <= res_chan_next;
                    res_bits_reg  <= res_bits_next;
                    res_rate_reg  <= res_rate_next;
                    res_fpos_reg  <= res_fpos_next;
                    res_fdone_reg <= res_fdone_next;
                    res_sdone_reg <= res_sdone_next;
                end
            end
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.kind        = res_kind_reg;
    assign result.out_byte    = res_byte_reg;
    assign result.num_chan    = res_chan_reg;
    assign result.sample_bits = res_bits_reg;
    assign result.rate_hz     = res_rate_reg;
    assign result.frame_pos   = res_fpos_reg;
    assign result.frame_done  = res_fdone_reg;
    assign result.stream_done = res_sdone_reg;

    `WRSP_ASSERT_NEXT(a_result_follows_word, accept,
        res_valid_reg == $past(has_result), "result register out of step with input word")
    `WRSP_ASSERT_NEXT(a_final_rearms, accept && fin,
        phase_reg == PH_RIFF && byte_count_reg == 4'd0 && !format_found_reg,
        "parser not rearmed after final word")
    `WRSP_ASSERT_NOW(a_format_legal, format_found_reg,
        (chan_reg == 16'd1 || chan_reg == 16'd2) && (bits_reg == 16'd8 || bits_reg == 16'd16),
        "accepted format holds illegal fields")
    `WRSP_ASSERT_NOW(a_data_needs_format, phase_reg == PH_DATA,
        format_found_reg, "data phase without accepted format")

endmodule

`default_nettype wire
